>>> sv/ftbs_pkg.sv
// shared types, constants and helpers of the flash tag and block status tracker
package ftbs_pkg;

  localparam int TAG_COUNT_DEF = 128;
  localparam int NODE_COUNT    = 4;
  localparam int BUS_COUNT     = 8;
  localparam int CHIP_COUNT    = 8;
  localparam int BLOCK_COUNT   = 4096;

  localparam int TAG_IDX_W  = 8;
  localparam int CNT_W      = 8;
  localparam int LOC_W      = 20;
  localparam int MAP_FA_W   = 4;
  localparam int MAP_FIELDS = 1 << MAP_FA_W;
  localparam int MAP_ROW_W  = 2 * MAP_FIELDS;
  localparam int MAP_RA_W   = LOC_W - MAP_FA_W;
  localparam int MAP_ROWS   = 1 << MAP_RA_W;

  typedef enum logic [3:0] {
    OP_ALLOC_RD = 4'd0,
    OP_ALLOC_WR = 4'd1,
    OP_ALLOC_ER = 4'd2,
    OP_ISSUE_ER = 4'd3,
    OP_ISSUE_WR = 4'd4,
    OP_ISSUE_RD = 4'd5,
    OP_DONE_RD  = 4'd6,
    OP_DONE_WR  = 4'd7,
    OP_DONE_ER  = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_UNINIT  = 2'd0,
    ST_ERASED  = 2'd1,
    ST_WRITTEN = 2'd2,
    ST_BAD     = 2'd3
  } blk_st_e;

  typedef enum logic [1:0] {
    POOL_RD = 2'd0,
    POOL_WR = 2'd1,
    POOL_ER = 2'd2
  } pool_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_ALLOC,
    S_MAP
  } state_e;

  typedef struct packed {
    logic [1:0]  node;
    logic [2:0]  bus;
    logic [2:0]  chip;
    logic [11:0] blk;
  } loc_t;

  typedef struct packed {
    logic [3:0] op;
    loc_t       loc;
    logic [6:0] tag;
    logic       failed;
  } item_t;

  typedef struct packed {
    logic [6:0]       tag_out;
    logic             alloc_ok;
    logic [CNT_W-1:0] reads_pending;
    logic [CNT_W-1:0] writes_pending;
    logic [CNT_W-1:0] erases_pending;
    logic             error_flag;
    logic [1:0]       block_state;
  } out_item_t;

  typedef struct packed {
    logic                 search;
    logic                 grab;
    logic                 free;
    pool_e                pool;
    logic [TAG_IDX_W-1:0] tag;
  } pool_ctl_t;

  typedef struct packed {
    logic                 found;
    logic [TAG_IDX_W-1:0] tag;
    logic                 busy;
  } pool_rsp_t;

  function automatic logic loc_ok(input loc_t l);
    return (int'(l.node) < NODE_COUNT) && (int'(l.bus) < BUS_COUNT) &&
           (int'(l.chip) < CHIP_COUNT) && (int'(l.blk) < BLOCK_COUNT);
  endfunction

  function automatic logic [MAP_RA_W-1:0] map_row(input loc_t l);
    logic [LOC_W-1:0] flat;
    flat = l;
    return flat[LOC_W-1:MAP_FA_W];
  endfunction

  function automatic logic [MAP_FA_W-1:0] map_fld(input loc_t l);
    logic [LOC_W-1:0] flat;
    flat = l;
    return flat[MAP_FA_W-1:0];
  endfunction

  function automatic logic [MAP_ROW_W-1:0] set_field(input logic [MAP_ROW_W-1:0] row,
                                                     input logic [MAP_FA_W-1:0] fld,
                                                     input blk_st_e st);
    logic [MAP_ROW_W-1:0] res;
    res = row;
    for (int i = 0; i < MAP_FIELDS; i++) begin
      if (fld == MAP_FA_W'(i)) begin
        res[2*i +: 2] = st;
      end
    end
    return res;
  endfunction

  function automatic blk_st_e get_field(input logic [MAP_ROW_W-1:0] row,
                                        input logic [MAP_FA_W-1:0] fld);
    blk_st_e res;
    res = ST_UNINIT;
    for (int i = 0; i < MAP_FIELDS; i++) begin
      if (fld == MAP_FA_W'(i)) begin
        res = blk_st_e'(row[2*i +: 2]);
      end
    end
    return res;
  endfunction

endpackage

>>> sv/ftbs_if.sv
// event and result channel interfaces of the flash tag and block status tracker
interface ftbs_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [1:0]  node_id;
  logic [2:0]  bus_id;
  logic [2:0]  chip_id;
  logic [11:0] block_id;
  logic [6:0]  req_tag;
  logic        erase_failed;

  modport source (
    output valid, opcode, node_id, bus_id, chip_id, block_id, req_tag, erase_failed,
    input  ready
  );
  modport sink (
    input  valid, opcode, node_id, bus_id, chip_id, block_id, req_tag, erase_failed,
    output ready
  );
endinterface

interface ftbs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] tag_out;
  logic       alloc_ok;
  logic [7:0] reads_pending;
  logic [7:0] writes_pending;
  logic [7:0] erases_pending;
  logic       error_flag;
  logic [1:0] block_state;

  modport source (
    output valid, tag_out, alloc_ok, reads_pending, writes_pending, erases_pending,
           error_flag, block_state,
    input  ready
  );
  modport sink (
    input  valid, tag_out, alloc_ok, reads_pending, writes_pending, erases_pending,
           error_flag, block_state,
    output ready
  );
endinterface

>>> sv/ftbs_ram.sv
// generic simple dual port ram with registered read
module ftbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ftbs_tag_pool.sv
// busy bits of the read, write and erase tag pools with a two step lowest free search
module ftbs_tag_pool #(
  parameter int TAG_COUNT = ftbs_pkg::TAG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ftbs_pkg::pool_ctl_t ctl,
  output ftbs_pkg::pool_rsp_t rsp
);
  import ftbs_pkg::*;

  localparam int TAG_W = $clog2(TAG_COUNT);
  localparam int GRP_N = (TAG_COUNT + 7) / 8;
  localparam int GRP_W = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int PAD_N = GRP_N * 8;

  logic [TAG_COUNT-1:0] busy_r   [3];
  logic [TAG_COUNT-1:0] busy_nxt [3];
  logic [TAG_COUNT-1:0] sel;
  logic [PAD_N-1:0]     pad;
  logic [GRP_W-1:0]     grp_r, grp_nxt, grp_ix;
  logic                 found_r, found_nxt, grp_hit;
  logic [7:0]           byte_bits;
  logic [2:0]           bit_ix;
  logic [TAG_IDX_W-1:0] alloc_tag;
  logic                 tag_in;

  assign sel = busy_r[ctl.pool];

  // tags past the pool size read as busy
  for (genvar i = 0; i < PAD_N; i++) begin : g_pad
    if (i < TAG_COUNT) begin : g_real
      assign pad[i] = sel[i];
    end else begin : g_fill
      assign pad[i] = 1'b1;
    end
  end

  // first group with a free tag
  always_comb begin
    grp_hit = 1'b0;
    grp_ix  = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (!(&pad[g*8 +: 8])) begin
        grp_hit = 1'b1;
        grp_ix  = GRP_W'(g);
      end
    end
  end

  // first free tag inside the registered group
  always_comb begin
    byte_bits = pad[{grp_r, 3'b000} +: 8];
    bit_ix    = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!byte_bits[b]) begin
        bit_ix = 3'(b);
      end
    end
  end

  assign alloc_tag = TAG_IDX_W'({grp_r, bit_ix});
  assign tag_in    = int'(ctl.tag) < TAG_COUNT;

  always_comb begin
    busy_nxt  = busy_r;
    grp_nxt   = ctl.search ? grp_ix : grp_r;
    found_nxt = ctl.search ? grp_hit : found_r;
    if (ctl.grab && found_r) begin
      busy_nxt[ctl.pool][alloc_tag[TAG_W-1:0]] = 1'b1;
    end
    if (ctl.free && tag_in) begin
      busy_nxt[ctl.pool][ctl.tag[TAG_W-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 3; p++) begin
        busy_r[p] <= '0;
      end
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r   <= grp_nxt;
    found_r <= found_nxt;
  end

  assign rsp.found = found_r;
  assign rsp.tag   = alloc_tag;
  assign rsp.busy  = tag_in && sel[ctl.tag[TAG_W-1:0]];

endmodule

>>> sv/flash_tag_and_block_status_tracker.sv
// top level of the flash tag and block status tracker
//
// Events enter on in_ch (valid/ready) and every event gives exactly one result on
// out_ch (valid/ready); a transfer happens when valid and ready are both high.
// Allocations hand out the lowest free tag of the read, write or erase pool,
// issues and completions keep the pending counts, the tag locations and the
// block status map, which sits in a ram of 2-bit entries packed 16 to a row.
// One event is worked on at a time. Issue events, write done and unknown
// opcodes give their result from the execute state; allocations, read done
// and erase done pass through the alloc or map state, as the location ram
// lookup is followed by a map row read, or for the two step free tag search.
// The next event is taken in the cycle after the result is written to the
// output register. After reset the map ram is cleared one row a cycle, all
// 65536 rows, while in_ch.ready stays low. Busy bits and counts clear at once.
// When the receiver stalls, the result waits in the output register; a second
// event is still taken and holds at its last step until the register frees.
module flash_tag_and_block_status_tracker #(
  parameter int TAG_COUNT = ftbs_pkg::TAG_COUNT_DEF
) (
  input logic            clk,
  input logic            rst_n,
  ftbs_in_if.sink        in_ch,
  ftbs_out_if.source     out_ch
);
  import ftbs_pkg::*;

  localparam int TAG_W     = $clog2(TAG_COUNT);
  localparam int LOC_AW    = TAG_W + 1;
  localparam int LOC_DEPTH = 2 << TAG_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'((TAG_COUNT > 255) ? 255 : TAG_COUNT);

  state_e           state_r, state_nxt;
  item_t            item_r, item_nxt;
  loc_t             lk_r, lk_nxt, lk, in_loc;
  logic [CNT_W-1:0] cnt_r   [3];
  logic [CNT_W-1:0] cnt_nxt [3];
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic [MAP_RA_W-1:0] clr_r, clr_nxt;

  logic       in_rdy, slot_free, fire, tag_ok;
  pool_e      pool_sel;
  logic [TAG_W-1:0] item_tix, in_tix;
  blk_st_e    cur_st;

  logic              loc_we, loc_re;
  logic [LOC_AW-1:0] loc_waddr, loc_raddr;
  logic [LOC_W-1:0]  loc_wdata, loc_rdata;

  logic                 map_we, map_re;
  logic [MAP_RA_W-1:0]  map_waddr, map_raddr;
  logic [MAP_ROW_W-1:0] map_wdata, map_rdata;

  pool_ctl_t pctl;
  pool_rsp_t prsp;

  ftbs_ram #(
    .WIDTH (LOC_W),
    .DEPTH (LOC_DEPTH)
  ) u_loc_ram (
    .clk   (clk),
    .we    (loc_we),
    .waddr (loc_waddr),
    .wdata (loc_wdata),
    .re    (loc_re),
    .raddr (loc_raddr),
    .rdata (loc_rdata)
  );

  ftbs_ram #(
    .WIDTH (MAP_ROW_W),
    .DEPTH (MAP_ROWS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  ftbs_tag_pool #(
    .TAG_COUNT (TAG_COUNT)
  ) u_tag_pool (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .rsp   (prsp)
  );

  assign in_loc.node = in_ch.node_id;
  assign in_loc.bus  = in_ch.bus_id;
  assign in_loc.chip = in_ch.chip_id;
  assign in_loc.blk  = in_ch.block_id;

  assign in_tix    = TAG_W'({1'b0, in_ch.req_tag});
  assign item_tix  = TAG_W'({1'b0, item_r.tag});
  assign tag_ok    = int'(item_r.tag) < TAG_COUNT;
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    case (item_r.op) inside
      OP_ALLOC_RD, OP_ISSUE_RD, OP_DONE_RD: pool_sel = POOL_RD;
      OP_ALLOC_WR, OP_ISSUE_WR, OP_DONE_WR: pool_sel = POOL_WR;
      default:                              pool_sel = POOL_ER;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    lk_nxt    = lk_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    in_rdy    = 1'b0;
    fire      = 1'b0;
    lk        = '0;
    cur_st    = ST_UNINIT;
    loc_we    = 1'b0;
    loc_waddr = '0;
    loc_wdata = '0;
    loc_re    = 1'b0;
    loc_raddr = '0;
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = '0;
    map_re    = 1'b0;
    map_raddr = '0;
    pctl      = '0;
    pctl.pool = pool_sel;
    pctl.tag  = TAG_IDX_W'(item_r.tag);

    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == MAP_RA_W'(MAP_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          item_nxt.op     = in_ch.opcode;
          item_nxt.loc    = in_loc;
          item_nxt.tag    = in_ch.req_tag;
          item_nxt.failed = in_ch.erase_failed;
          loc_re          = 1'b1;
          loc_raddr       = {in_ch.opcode == OP_DONE_ER, in_tix};
          map_re          = 1'b1;
          map_raddr       = map_row(in_loc);
          state_nxt       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_r.op) inside
          OP_ALLOC_RD, OP_ALLOC_WR, OP_ALLOC_ER: begin
            pctl.search = 1'b1;
            state_nxt   = S_ALLOC;
          end
          OP_DONE_RD, OP_DONE_ER: begin
            // unknown tags look up location zero
            lk        = tag_ok ? loc_t'(loc_rdata) : '0;
            lk_nxt    = lk;
            map_re    = 1'b1;
            map_raddr = map_row(lk);
            state_nxt = S_MAP;
          end
          default: begin
            if (slot_free) begin
              fire      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_ALLOC, S_MAP: begin
        if (slot_free) begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (fire) begin
      out_nxt.tag_out     = item_r.tag;
      out_nxt.alloc_ok    = 1'b0;
      out_nxt.error_flag  = 1'b0;
      out_nxt.block_state = ST_UNINIT;
      case (item_r.op) inside
        OP_ALLOC_RD, OP_ALLOC_WR, OP_ALLOC_ER: begin
          pctl.grab        = 1'b1;
          out_nxt.alloc_ok = prsp.found;
          out_nxt.tag_out  = prsp.found ? prsp.tag[6:0] : '0;
        end
        OP_ISSUE_ER, OP_ISSUE_WR, OP_ISSUE_RD: begin
          if (cnt_r[pool_sel] < CNT_MAX) begin
            cnt_nxt[pool_sel] = cnt_r[pool_sel] + 1'b1;
          end
          if (item_r.op != OP_ISSUE_WR && tag_ok) begin
            loc_we    = 1'b1;
            loc_waddr = {item_r.op == OP_ISSUE_ER, item_tix};
            loc_wdata = item_r.loc;
          end
          cur_st    = get_field(map_rdata, map_fld(item_r.loc));
          map_waddr = map_row(item_r.loc);
          if (item_r.op == OP_ISSUE_ER) begin
            map_we    = loc_ok(item_r.loc);
            map_wdata = set_field(map_rdata, map_fld(item_r.loc), ST_ERASED);
          end else if (item_r.op == OP_ISSUE_WR) begin
            map_we    = loc_ok(item_r.loc) && cur_st != ST_BAD;
            map_wdata = set_field(map_rdata, map_fld(item_r.loc), ST_WRITTEN);
          end
        end
        OP_DONE_RD, OP_DONE_WR, OP_DONE_ER: begin
          pctl.free          = 1'b1;
          out_nxt.error_flag = (cnt_r[pool_sel] == '0) || !tag_ok || !prsp.busy;
          if (cnt_r[pool_sel] != '0) begin
            cnt_nxt[pool_sel] = cnt_r[pool_sel] - 1'b1;
          end
          if (item_r.op == OP_DONE_RD && loc_ok(lk_r)) begin
            out_nxt.block_state = get_field(map_rdata, map_fld(lk_r));
          end
          if (item_r.op == OP_DONE_ER) begin
            map_we    = item_r.failed && tag_ok && loc_ok(lk_r);
            map_waddr = map_row(lk_r);
            map_wdata = set_field(map_rdata, map_fld(lk_r), ST_BAD);
          end
        end
        default: begin
        end
      endcase
      out_nxt.reads_pending  = cnt_nxt[POOL_RD];
      out_nxt.writes_pending = cnt_nxt[POOL_WR];
      out_nxt.erases_pending = cnt_nxt[POOL_ER];
    end

    out_valid_nxt = fire || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < 3; p++) begin
        cnt_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    lk_r   <= lk_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready           = in_rdy;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.tag_out        = out_r.tag_out;
  assign out_ch.alloc_ok       = out_r.alloc_ok;
  assign out_ch.reads_pending  = out_r.reads_pending;
  assign out_ch.writes_pending = out_r.writes_pending;
  assign out_ch.erases_pending = out_r.erases_pending;
  assign out_ch.error_flag     = out_r.error_flag;
  assign out_ch.block_state    = out_r.block_state;

endmodule

>>> sv/ftbs_checker.sv
// port level assertions of the flash tag and block status tracker and their bind
module ftbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] tag_out,
  input logic       alloc_ok,
  input logic [7:0] reads_pending,
  input logic [7:0] writes_pending,
  input logic [7:0] erases_pending,
  input logic       error_flag,
  input logic [1:0] block_state
);
  import ftbs_pkg::*;

  // map clear keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // one event at a time: input ready drops after each transfer
  a_one_event_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer on the cycle after a transfer");

  a_alloc_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && alloc_ok |-> !error_flag && block_state == ST_UNINIT)
    else $error("allocation result carries error or block state");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tag_out) && $stable(alloc_ok) &&
      $stable(reads_pending) && $stable(writes_pending) && $stable(erases_pending) &&
      $stable(error_flag) && $stable(block_state))
    else $error("result changed while stalled");

endmodule

bind flash_tag_and_block_status_tracker ftbs_checker u_ftbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .tag_out        (out_ch.tag_out),
  .alloc_ok       (out_ch.alloc_ok),
  .reads_pending  (out_ch.reads_pending),
  .writes_pending (out_ch.writes_pending),
  .erases_pending (out_ch.erases_pending),
  .error_flag     (out_ch.error_flag),
  .block_state    (out_ch.block_state)
);
